FILE: src/plane_distance_offset_normalizer_core_defines.svh
// assertion macros for the plane distance offset normalizer
`ifndef PLANE_DISTANCE_OFFSET_NORMALIZER_CORE_DEFINES_SVH
`define PLANE_DISTANCE_OFFSET_NORMALIZER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PDON_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define PDON_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/pdon_pkg.sv
package pdon_pkg;

	localparam int MAX_VERTICES    = 64;
	localparam int COORD_FRAC_BITS = 16;
	localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW  = $clog2(MAX_VERTICES + 1);
	localparam int DW  = 52;

	typedef enum logic [1:0] {
		OP_ROW   = 2'd0,
		OP_POINT = 2'd1,
		OP_DIR   = 2'd2,
		OP_VERT  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_XFORM,
		ST_STORE,
		ST_FETCH,
		ST_LOAD,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	// exact product, magnitude truncated by the fraction bits, sign restored
	function automatic logic signed [63:0] mul_frac(input logic signed [32:0] a,
			input logic signed [31:0] b);
		logic        neg;
		logic [32:0] ma;
		logic [31:0] mb;
		logic [64:0] p;
		logic [63:0] m;
		neg = a[32] ^ b[31];
		ma  = a[32] ? 33'(-a) : 33'(a);
		mb  = b[31] ? 32'(-b) : 32'(b);
		p   = 65'(ma) * 65'(mb);
		m   = 64'(p >> COORD_FRAC_BITS);
		return neg ? -$signed(m) : $signed(m);
	endfunction

endpackage

FILE: src/plane_distance_offset_normalizer_core.sv
// plane distance offset normalizer
// input channel (in_valid/in_stall) carries load items and vertices; a
// transfer happens when in_valid is high and in_stall is low. a vertex
// runs a shared 33x32 multiplier over three world axes, then writes its
// distance to the distance memory; in_stall stays high until then. a
// vertex beyond capacity is not stored and sets the dropped flag.
// on a vertex with end_of_frame set, every stored distance is read from
// the memory (registered read), divided by the peak magnitude in a
// radix-2 divider and sent on the output channel (out_valid/out_stall).
// in_stall stays high until the frame's last result is handed to the
// output register.
// the output register holds its payload while out_stall is high and the
// sequencer waits for it before loading the next result.
// reset clears transform, point, direction, peak, count and flags; the
// distance memory needs no clearing since only written entries are read.
`include "plane_distance_offset_normalizer_core_defines.svh"

module plane_distance_offset_normalizer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [1:0]         row_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic               end_of_frame,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] offset,
	output logic [5:0]         vertex_number,
	output logic               final_item,
	output logic               dropped
);

	pdon_pkg::state_t state_q, state_d;

	logic signed [31:0] coef_q [12];
	logic signed [31:0] point_q [3];
	logic signed [31:0] dir_q [3];
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic               eof_q;
	logic [pdon_pkg::CW-1:0] count_q, k_q;
	logic [pdon_pkg::DW-1:0] peak_q, rem_q;
	logic               ovf_q;
	logic [2:0]         sub_q;
	logic [1:0]         j_q;
	logic [3:0]         dcnt_q;
	logic [15:0]        quo_q;
	logic               neg_q;
	logic signed [63:0] prod_q, acc_q, dist_q;
	logic signed [32:0] wd_q;
	logic signed [63:0] mem [pdon_pkg::MAX_VERTICES];
	logic signed [63:0] rd_q;

	logic in_xfer, out_xfer, out_free, full, last_k;
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] mul_p, sat_w;
	logic [3:0] row_base;
	logic [63:0] dist_mag, rd_mag;
	logic [pdon_pkg::DW-1:0] shifted;
	logic ge;
	logic signed [15:0] q_val;
	logic do_emit;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign out_free = !out_valid || !out_stall;
	assign full     = (count_q == pdon_pkg::CW'(pdon_pkg::MAX_VERTICES));
	assign last_k   = (pdon_pkg::CW'(k_q + 1'b1) == count_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pdon_pkg::ST_IDLE: begin
				if (in_xfer && operation == pdon_pkg::OP_VERT) begin
					if (!full)
						state_d = pdon_pkg::ST_XFORM;
					else if (end_of_frame)
						state_d = pdon_pkg::ST_FETCH;
				end
			end
			pdon_pkg::ST_XFORM: begin
				if (sub_q == 3'd6 && j_q == 2'd2)
					state_d = pdon_pkg::ST_STORE;
			end
			pdon_pkg::ST_STORE: state_d = eof_q ? pdon_pkg::ST_FETCH : pdon_pkg::ST_IDLE;
			pdon_pkg::ST_FETCH: state_d = pdon_pkg::ST_LOAD;
			pdon_pkg::ST_LOAD:  state_d = pdon_pkg::ST_DIVIDE;
			pdon_pkg::ST_DIVIDE: begin
				if (dcnt_q == 4'd15)
					state_d = pdon_pkg::ST_EMIT;
			end
			pdon_pkg::ST_EMIT: begin
				if (out_free)
					state_d = last_k ? pdon_pkg::ST_IDLE : pdon_pkg::ST_FETCH;
			end
			default: state_d = pdon_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = (state_q != pdon_pkg::ST_IDLE);
		do_emit  = (state_q == pdon_pkg::ST_EMIT) && out_free;
	end

	// shared multiplier operand selection
	always_comb begin
		row_base = 4'd0;
		mul_a    = 33'(cx_q);
		unique case (sub_q)
			3'd1:    begin row_base = 4'd3; mul_a = 33'(cy_q); end
			3'd2:    begin row_base = 4'd6; mul_a = 33'(cz_q); end
			3'd5:    mul_a = wd_q;
			default: begin row_base = 4'd0; mul_a = 33'(cx_q); end
		endcase
		mul_b = (sub_q == 3'd5) ? dir_q[j_q] : coef_q[row_base + 4'(j_q)];
		mul_p = pdon_pkg::mul_frac(mul_a, mul_b);
	end

	always_comb begin
		if (acc_q > 64'sd2147483647)
			sat_w = 64'sd2147483647;
		else if (acc_q < -64'sd2147483648)
			sat_w = -64'sd2147483648;
		else
			sat_w = acc_q;
	end

	assign dist_mag = dist_q[63] ? 64'(-dist_q) : 64'(dist_q);
	assign rd_mag   = rd_q[63] ? 64'(-rd_q) : 64'(rd_q);
	assign shifted  = (dcnt_q == 4'd0) ? rem_q : {rem_q[pdon_pkg::DW-2:0], 1'b0};
	assign ge       = (shifted >= peak_q);

	always_comb begin
		if (peak_q == '0)
			q_val = 16'sd0;
		else if (neg_q)
			q_val = -$signed(quo_q);
		else if (quo_q[15])
			q_val = 16'sd32767;
		else
			q_val = $signed(quo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pdon_pkg::ST_IDLE;
			count_q   <= '0;
			peak_q    <= '0;
			ovf_q     <= 1'b0;
			k_q       <= '0;
			sub_q     <= '0;
			j_q       <= '0;
			dcnt_q    <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < 12; i++)
				coef_q[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				point_q[i] <= '0;
				dir_q[i]   <= '0;
			end
		end else begin
			state_q <= state_d;
			if (do_emit)
				out_valid <= 1'b1;
			else if (out_xfer)
				out_valid <= 1'b0;
			if (in_xfer) begin
				unique case (operation)
					pdon_pkg::OP_ROW: begin
						coef_q[4'(row_index) * 4'd3]        <= coord_x;
						coef_q[4'(row_index) * 4'd3 + 4'd1] <= coord_y;
						coef_q[4'(row_index) * 4'd3 + 4'd2] <= coord_z;
					end
					pdon_pkg::OP_POINT: begin
						point_q[0] <= coord_x;
						point_q[1] <= coord_y;
						point_q[2] <= coord_z;
					end
					pdon_pkg::OP_DIR: begin
						dir_q[0] <= coord_x;
						dir_q[1] <= coord_y;
						dir_q[2] <= coord_z;
					end
					pdon_pkg::OP_VERT: begin
						sub_q <= '0;
						j_q   <= '0;
						k_q   <= '0;
						if (full)
							ovf_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (state_q == pdon_pkg::ST_XFORM) begin
				if (sub_q == 3'd6) begin
					sub_q <= '0;
					j_q   <= 2'(j_q + 1'b1);
				end else begin
					sub_q <= 3'(sub_q + 1'b1);
				end
			end
			if (state_q == pdon_pkg::ST_STORE) begin
				count_q <= pdon_pkg::CW'(count_q + 1'b1);
				if (dist_mag[pdon_pkg::DW-1:0] > peak_q)
					peak_q <= dist_mag[pdon_pkg::DW-1:0];
			end
			if (state_q == pdon_pkg::ST_LOAD)
				dcnt_q <= '0;
			else if (state_q == pdon_pkg::ST_DIVIDE)
				dcnt_q <= 4'(dcnt_q + 1'b1);
			if (do_emit) begin
				k_q <= pdon_pkg::CW'(k_q + 1'b1);
				if (last_k) begin
					count_q <= '0;
					peak_q  <= '0;
					ovf_q   <= 1'b0;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cx_q   <= coord_x;
			cy_q   <= coord_y;
			cz_q   <= coord_z;
			eof_q  <= end_of_frame;
			dist_q <= '0;
		end
		if (state_q == pdon_pkg::ST_XFORM) begin
			unique case (sub_q)
				3'd0: begin
					prod_q <= mul_p;
					acc_q  <= 64'(coef_q[4'd9 + 4'(j_q)]);
				end
				3'd1, 3'd2: begin
					prod_q <= mul_p;
					acc_q  <= acc_q + prod_q;
				end
				3'd3: acc_q <= acc_q + prod_q;
				3'd4: wd_q <= 33'(sat_w) - 33'(point_q[j_q]);
				3'd5: prod_q <= mul_p;
				default: dist_q <= dist_q + prod_q;
			endcase
		end
		if (state_q == pdon_pkg::ST_LOAD) begin
			rem_q <= rd_mag[pdon_pkg::DW-1:0];
			neg_q <= rd_q[63];
			quo_q <= '0;
		end
		if (state_q == pdon_pkg::ST_DIVIDE) begin
			rem_q <= ge ? shifted - peak_q : shifted;
			quo_q <= {quo_q[14:0], ge};
		end
		if (do_emit) begin
			offset        <= q_val;
			vertex_number <= 6'(k_q[pdon_pkg::AW-1:0]);
			final_item    <= last_k;
			dropped       <= ovf_q;
		end
	end

	// distance memory
	always_ff @(posedge clk) begin
		if (state_q == pdon_pkg::ST_STORE)
			mem[count_q[pdon_pkg::AW-1:0]] <= dist_q;
		rd_q <= mem[k_q[pdon_pkg::AW-1:0]];
	end

	`PDON_ASSERT_NOW(a_count_bound, 1'b1,
		count_q <= pdon_pkg::CW'(pdon_pkg::MAX_VERTICES), "vertex count above capacity")
	`PDON_ASSERT_NOW(a_store_room, state_q == pdon_pkg::ST_STORE, !full,
		"distance stored into a full memory")
	`PDON_ASSERT_NOW(a_div_rem, state_q == pdon_pkg::ST_DIVIDE, rem_q <= peak_q,
		"divider remainder above peak")
	`PDON_ASSERT_NEXT(a_frame_clear, do_emit && last_k,
		count_q == '0 && peak_q == '0 && !ovf_q, "frame state not cleared after last result")

endmodule
